/* rtl/core/tpao_pkg.sv */
`default_nettype none
package tpao_pkg;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EQUAL = 2'd1;
   localparam logic [1:0] ST_ZERO  = 2'd2;
   localparam logic [1:0] ST_DEN   = 2'd3;

   localparam logic [48:0] MAG_POS = 49'h0_FFFF_FFFF_FFFF;
   localparam logic [48:0] MAG_NEG = 49'h1_0000_0000_0000;

   // classified request, pools renamed so that ETH enters pool 1 and leaves pool 2
   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] x1;
      logic [31:0] y1;
      logic [31:0] x2;
      logic [31:0] y2;
   } tpao_item_type;

   // signed 49-bit saturation of a sign/magnitude quotient
   function automatic logic [48:0] sat_mag(input logic neg, input logic ovf,
                                           input logic [48:0] q);
      logic [48:0] r;
      if (neg) begin
         if (ovf || q > MAG_NEG) r = MAG_NEG;
         else r = ~q + 49'd1;
      end else begin
         if (ovf || q > MAG_POS) r = MAG_POS;
         else r = q;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* rtl/core/tpao_mul.sv */
`default_nettype none
module tpao_mul #(
   parameter int AW = 32,
   parameter int BW = 32
) (
   input  logic             clock,
   input  logic             en,
   input  logic [AW-1:0]    a,
   input  logic [BW-1:0]    b,
   output logic [AW+BW-1:0] p
);
   localparam int NA = (AW + 31) / 32;
   localparam int NB = (BW + 31) / 32;
   localparam int PA = 32 * NA;
   localparam int PB = 32 * NB;
   localparam int SW = PA + PB;

   logic [PA-1:0]    a_pad;
   logic [PB-1:0]    b_pad;
   logic [63:0]      part_ff [NA*NB];
   logic [SW-1:0]    acc;
   logic [AW+BW-1:0] p_ff;
   logic [AW+BW-1:0] p_in;

   assign a_pad = PA'(a);
   assign b_pad = PB'(b);

   // stage 1: 32x32 partial products
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
               part_ff[i*NB+j] <= 64'(a_pad[32*i +: 32]) * 64'(b_pad[32*j +: 32]);
            end
         end
      end
   end

   // stage 2: shifted sum
   always_comb begin
      acc = '0;
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            acc = acc + (SW'(part_ff[i*NB+j]) << (32 * (i + j)));
         end
      end
      p_in = acc[AW+BW-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) p_ff <= p_in;
   end

   assign p = p_ff;
endmodule
`default_nettype wire

/* rtl/core/tpao_sqrt.sv */
`default_nettype none
module tpao_sqrt #(
   parameter int NW = 128,
   parameter int CW = 1
) (
   input  logic              clock,
   input  logic              en,
   input  logic [NW-1:0]     n,
   input  logic [CW-1:0]     ctx_in,
   output logic [NW/2-1:0]   root,
   output logic [CW-1:0]     ctx_out
);
   localparam int RW = NW / 2;

   logic [NW-1:0] rem_ff  [RW];
   logic [RW-1:0] root_ff [RW];
   logic [CW-1:0] ctx_ff  [RW];

   // one root bit per stage, MSB first
   for (genvar s = 0; s < RW; s++) begin : g_stage
      localparam int K = RW - 1 - s;
      logic [NW-1:0] rem_i;
      logic [RW-1:0] root_i;
      logic [CW-1:0] ctx_i;
      logic [NW-1:0] trial;
      logic          ge;

      if (s == 0) begin : g_first
         assign rem_i  = n;
         assign root_i = '0;
         assign ctx_i  = ctx_in;
      end else begin : g_next
         assign rem_i  = rem_ff[s-1];
         assign root_i = root_ff[s-1];
         assign ctx_i  = ctx_ff[s-1];
      end

      assign trial = (NW'(root_i) << (K + 1)) + (NW'(1) << (2 * K));
      assign ge    = rem_i >= trial;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= ge ? rem_i - trial : rem_i;
            root_ff[s] <= ge ? (root_i | (RW'(1) << K)) : root_i;
            ctx_ff[s]  <= ctx_i;
         end
      end
   end

   assign root    = root_ff[RW-1];
   assign ctx_out = ctx_ff[RW-1];
endmodule
`default_nettype wire

/* rtl/core/tpao_div.sv */
`default_nettype none
module tpao_div #(
   parameter int NW = 113,
   parameter int DW = 67,
   parameter int QW = 49,
   parameter int CW = 1
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] n,
   input  logic [DW-1:0] d,
   input  logic [CW-1:0] ctx_in,
   output logic [QW-1:0] q,
   output logic          ovf,
   output logic [CW-1:0] ctx_out
);
   localparam int WW = (NW > DW + QW) ? NW : DW + QW;

   logic [WW-1:0] r0_ff;
   logic [DW-1:0] d0_ff;
   logic          ovf0_ff;
   logic [CW-1:0] ctx0_ff;

   logic [WW-1:0] r_ff   [QW];
   logic [DW-1:0] d_ff   [QW];
   logic [QW-1:0] q_ff   [QW];
   logic          ovf_ff [QW];
   logic [CW-1:0] ctx_ff [QW];

   // range check: quotient does not fit in QW bits
   always_ff @(posedge clock) begin
      if (en) begin
         r0_ff   <= WW'(n);
         d0_ff   <= d;
         ovf0_ff <= WW'(n) >= (WW'(d) << QW);
         ctx0_ff <= ctx_in;
      end
   end

   // restoring division, one quotient bit per stage
   for (genvar s = 0; s < QW; s++) begin : g_stage
      localparam int K = QW - 1 - s;
      logic [WW-1:0] r_i;
      logic [DW-1:0] d_i;
      logic [QW-1:0] q_i;
      logic          ovf_i;
      logic [CW-1:0] ctx_i;
      logic [WW-1:0] dsh;
      logic          ge;

      if (s == 0) begin : g_first
         assign r_i   = r0_ff;
         assign d_i   = d0_ff;
         assign q_i   = '0;
         assign ovf_i = ovf0_ff;
         assign ctx_i = ctx0_ff;
      end else begin : g_next
         assign r_i   = r_ff[s-1];
         assign d_i   = d_ff[s-1];
         assign q_i   = q_ff[s-1];
         assign ovf_i = ovf_ff[s-1];
         assign ctx_i = ctx_ff[s-1];
      end

      assign dsh = WW'(d_i) << K;
      assign ge  = r_i >= dsh;

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[s]   <= ge ? r_i - dsh : r_i;
            d_ff[s]   <= d_i;
            q_ff[s]   <= ge ? (q_i | (QW'(1) << K)) : q_i;
            ovf_ff[s] <= ovf_i;
            ctx_ff[s] <= ctx_i;
         end
      end
   end

   assign q       = q_ff[QW-1];
   assign ovf     = ovf_ff[QW-1];
   assign ctx_out = ctx_ff[QW-1];
endmodule
`default_nettype wire

/* rtl/core/tpao_front.sv */
`default_nettype none
module tpao_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [31:0]            a_eth,
   input  logic [31:0]            a_dai,
   input  logic [31:0]            b_eth,
   input  logic [31:0]            b_dai,
   output logic                   out_valid,
   input  logic                   out_ready,
   output tpao_pkg::tpao_item_type out_item
);
   import tpao_pkg::*;

   logic          a_vld_ff;
   logic [31:0]   ae_ff, ad_ff, be_ff, bd_ff;
   logic [63:0]   lhs_ff, rhs_ff;
   logic          b_vld_ff;
   tpao_item_type item_ff;
   tpao_item_type item_in;
   logic          a_ready;
   logic          b_ready;

   assign b_ready  = !b_vld_ff || out_ready;
   assign a_ready  = !a_vld_ff || b_ready;
   assign in_ready = a_ready;

   // stage A: cross products of the prices
   always_ff @(posedge clock) begin
      if (reset) a_vld_ff <= 1'b0;
      else if (a_ready) a_vld_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         ae_ff  <= a_eth;
         ad_ff  <= a_dai;
         be_ff  <= b_eth;
         bd_ff  <= b_dai;
         lhs_ff <= 64'(a_eth) * 64'(b_dai);
         rhs_ff <= 64'(b_eth) * 64'(a_dai);
      end
   end

   // stage B: classify and pick the direction
   always_comb begin
      if (ae_ff == '0 || ad_ff == '0 || be_ff == '0 || bd_ff == '0) item_in.status = ST_ZERO;
      else if (lhs_ff == rhs_ff) item_in.status = ST_EQUAL;
      else item_in.status = ST_OK;
      if (lhs_ff > rhs_ff) begin
         item_in.x1 = bd_ff;
         item_in.y1 = be_ff;
         item_in.x2 = ad_ff;
         item_in.y2 = ae_ff;
      end else begin
         item_in.x1 = ad_ff;
         item_in.y1 = ae_ff;
         item_in.x2 = bd_ff;
         item_in.y2 = be_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) b_vld_ff <= 1'b0;
      else if (b_ready) b_vld_ff <= a_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (b_ready) item_ff <= item_in;
   end

   assign out_valid = b_vld_ff;
   assign out_item  = item_ff;
endmodule
`default_nettype wire

/* rtl/core/tpao_queue.sv */
`default_nettype none
module tpao_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  tpao_pkg::tpao_item_type in_item,
   output logic                   out_valid,
   input  logic                   out_ready,
   output tpao_pkg::tpao_item_type out_item
);
   import tpao_pkg::*;

   localparam int QD = 2;
   localparam int PW = $clog2(QD);
   localparam int NW = $clog2(QD + 1);

   tpao_item_type mem_ff [QD];
   logic [PW-1:0] wr_ff, rd_ff;
   logic [NW-1:0] cnt_ff;
   logic          push, pop;

   assign in_ready  = cnt_ff != NW'(QD);
   assign out_valid = cnt_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_item  = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + PW'(1);
         if (pop) rd_ff <= rd_ff + PW'(1);
         if (push && !pop) cnt_ff <= cnt_ff + NW'(1);
         else if (pop && !push) cnt_ff <= cnt_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= in_item;
   end
endmodule
`default_nettype wire

/* rtl/core/tpao_back.sv */
`default_nettype none
module tpao_back #(
   parameter int FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [16:0]            gamma,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  tpao_pkg::tpao_item_type in_item,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic signed [48:0]     out_amount,
   output logic signed [48:0]     out_profit,
   output logic [1:0]             out_status
);
   import tpao_pkg::*;

   localparam int RW     = 64;
   localparam int QT     = 49;
   localparam int QE     = 50;
   localparam int DEN_W  = 67;
   localparam int N1W    = 97 + FRAC_BITS;
   localparam int GV_W   = 66;
   localparam int BASE_W = 48 + FRAC_BITS;
   localparam int SDW    = ((GV_W > BASE_W) ? GV_W : BASE_W) + 1;
   localparam int N2W    = 98 + FRAC_BITS;
   localparam int LAT    = 4 + RW + 2 + (QT + 1) + 4 + (QT + 1) + 4 + (QE + 1) + 1;

   typedef struct packed {
      tpao_item_type item;
      logic [63:0]   p2;
      logic [48:0]   gx2;
   } c2_type;
   typedef struct packed {
      tpao_item_type    item;
      logic [63:0]      p2;
      logic [DEN_W-1:0] den;
   } c3_type;
   typedef struct packed {
      tpao_item_type item;
      logic          tneg;
   } c4_type;
   typedef struct packed {
      tpao_item_type item;
      logic [48:0]   t;
   } c5_type;
   typedef struct packed {
      tpao_item_type  item;
      logic [48:0]    t;
      logic           fail;
      logic [SDW-1:0] den;
   } c6_type;
   typedef struct packed {
      tpao_item_type item;
      logic [48:0]   t;
      logic          fail;
   } c7_type;
   typedef struct packed {
      tpao_item_type item;
      logic [48:0]   t;
      logic          fail;
      logic          dsn;
   } c8_type;
   typedef struct packed {
      tpao_item_type  item;
      logic [48:0]    t;
      logic           fail;
      logic           dsn;
      logic [SDW-1:0] den;
   } c9_type;
   typedef struct packed {
      logic [1:0]  status;
      logic [48:0] t;
      logic        fail;
      logic        dsn;
   } c10_type;

   logic            en;
   logic [LAT-1:0]  vld_ff;

   tpao_item_type   it1a_ff, it1b_ff;
   logic [63:0]     p1, p2;
   logic [48:0]     gx2;
   logic [33:0]     gg;
   c2_type          c2_in, c2a_ff, c2b_ff;
   logic [127:0]    pp;
   logic [65:0]     ggx1;
   c3_type          c3_in, c3_out, c3a_ff, c3b_ff;
   logic [RW-1:0]   root;
   logic [80:0]     rg;
   logic [96:0]     pos, negp, tdif;
   logic            tneg;
   c4_type          c4_in, c4_out;
   logic [QT-1:0]   q1;
   logic            ovf1;
   logic [48:0]     t_val, t_abs;
   c5_type          c5_in, c5a_ff, c5b_ff;
   logic [GV_W-1:0] gv1;
   logic [SDW-1:0]  base1, gv1_x;
   logic            fail1;
   c6_type          c6_in, c6a_ff, c6b_ff;
   logic [97:0]     num1;
   c7_type          c7_in, c7_out;
   logic [QT-1:0]   q2;
   logic            ovf2;
   logic [48:0]     d_val, d_abs;
   c8_type          c8_in, c8a_ff, c8b_ff;
   logic [GV_W-1:0] gv2;
   logic [SDW-1:0]  base2, gv2_x;
   logic            fail2;
   c9_type          c9_in, c9a_ff, c9b_ff;
   logic [97:0]     num2;
   c10_type         c10_in, c10_out;
   logic [QE-1:0]   q3;
   logic            ovf3;
   logic [52:0]     emag;
   logic signed [52:0] e_s, t_s, p_s;
   logic [48:0]     amount_in, profit_in;
   logic [1:0]      status_in;
   logic [48:0]     amount_ff, profit_ff;
   logic [1:0]      status_ff;

   localparam logic signed [52:0] P_MAX = 53'sh0_FFFF_FFFF_FFFF;
   localparam logic signed [52:0] P_MIN = -53'sh1_0000_0000_0000;

   // whole pipeline advances together; only a held result stops it
   assign en       = !vld_ff[LAT-1] || out_ready;
   assign in_ready = en;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (en) vld_ff <= {vld_ff[LAT-2:0], in_valid};
   end

   // cross products, gamma*x2 and gamma^2
   tpao_mul #(.AW(32), .BW(32)) u_p1 (.clock(clock), .en(en),
      .a(in_item.x1), .b(in_item.y2), .p(p1));
   tpao_mul #(.AW(32), .BW(32)) u_p2 (.clock(clock), .en(en),
      .a(in_item.x2), .b(in_item.y1), .p(p2));
   tpao_mul #(.AW(17), .BW(32)) u_gx2 (.clock(clock), .en(en),
      .a(gamma), .b(in_item.x2), .p(gx2));
   tpao_mul #(.AW(17), .BW(17)) u_gg (.clock(clock), .en(en),
      .a(gamma), .b(gamma), .p(gg));

   // radicand and the gamma^2*x1 term
   tpao_mul #(.AW(64), .BW(64)) u_pp (.clock(clock), .en(en),
      .a(p1), .b(p2), .p(pp));
   tpao_mul #(.AW(34), .BW(32)) u_ggx1 (.clock(clock), .en(en),
      .a(gg), .b(it1b_ff.x1), .p(ggx1));

   assign c2_in.item = it1b_ff;
   assign c2_in.p2   = p2;
   assign c2_in.gx2  = gx2;

   assign c3_in.item = c2b_ff.item;
   assign c3_in.p2   = c2b_ff.p2;
   assign c3_in.den  = (DEN_W'(c2b_ff.gx2) << 16) + DEN_W'(ggx1);

   tpao_sqrt #(.NW(128), .CW($bits(c3_type))) u_sqrt (.clock(clock), .en(en),
      .n(pp), .ctx_in(c3_in), .root(root), .ctx_out(c3_out));

   tpao_mul #(.AW(RW), .BW(17)) u_rg (.clock(clock), .en(en),
      .a(root), .b(gamma), .p(rg));

   // numerator of t in sign/magnitude form
   assign pos  = {rg, 16'b0};
   assign negp = {1'b0, c3b_ff.p2, 32'b0};
   assign tneg = pos < negp;
   assign tdif = tneg ? negp - pos : pos - negp;

   assign c4_in.item = c3b_ff.item;
   assign c4_in.tneg = tneg;

   tpao_div #(.NW(N1W), .DW(DEN_W), .QW(QT), .CW($bits(c4_type))) u_div_t (
      .clock(clock), .en(en), .n(N1W'(tdif) << FRAC_BITS), .d(c3b_ff.den),
      .ctx_in(c4_in), .q(q1), .ovf(ovf1), .ctx_out(c4_out));

   assign t_val = sat_mag(c4_out.tneg, ovf1, q1);
   assign t_abs = t_val[48] ? ~t_val + 49'd1 : t_val;

   assign c5_in.item = c4_out.item;
   assign c5_in.t    = t_val;

   // first swap: ETH into pool 1
   tpao_mul #(.AW(49), .BW(17)) u_gv1 (.clock(clock), .en(en),
      .a(t_abs), .b(gamma), .p(gv1));

   assign base1 = SDW'(BASE_W'(c5b_ff.item.y1) << (16 + FRAC_BITS));
   assign gv1_x = SDW'(gv1);
   assign fail1 = c5b_ff.t[48] && (gv1_x >= base1);

   assign c6_in.item = c5b_ff.item;
   assign c6_in.t    = c5b_ff.t;
   assign c6_in.fail = fail1;
   assign c6_in.den  = c5b_ff.t[48] ? base1 - gv1_x : base1 + gv1_x;

   tpao_mul #(.AW(GV_W), .BW(32)) u_num1 (.clock(clock), .en(en),
      .a(gv1), .b(c5b_ff.item.x1), .p(num1));

   assign c7_in.item = c6b_ff.item;
   assign c7_in.t    = c6b_ff.t;
   assign c7_in.fail = c6b_ff.fail;

   tpao_div #(.NW(N2W), .DW(SDW), .QW(QT), .CW($bits(c7_type))) u_div_d (
      .clock(clock), .en(en), .n(N2W'(num1) << FRAC_BITS), .d(c6b_ff.den),
      .ctx_in(c7_in), .q(q2), .ovf(ovf2), .ctx_out(c7_out));

   assign d_val = sat_mag(c7_out.t[48], ovf2, q2);
   assign d_abs = d_val[48] ? ~d_val + 49'd1 : d_val;

   assign c8_in.item = c7_out.item;
   assign c8_in.t    = c7_out.t;
   assign c8_in.fail = c7_out.fail;
   assign c8_in.dsn  = d_val[48];

   // second swap: DAI into pool 2
   tpao_mul #(.AW(49), .BW(17)) u_gv2 (.clock(clock), .en(en),
      .a(d_abs), .b(gamma), .p(gv2));

   assign base2 = SDW'(BASE_W'(c8b_ff.item.x2) << (16 + FRAC_BITS));
   assign gv2_x = SDW'(gv2);
   assign fail2 = c8b_ff.dsn && (gv2_x >= base2);

   assign c9_in.item = c8b_ff.item;
   assign c9_in.t    = c8b_ff.t;
   assign c9_in.fail = c8b_ff.fail || fail2;
   assign c9_in.dsn  = c8b_ff.dsn;
   assign c9_in.den  = c8b_ff.dsn ? base2 - gv2_x : base2 + gv2_x;

   tpao_mul #(.AW(GV_W), .BW(32)) u_num2 (.clock(clock), .en(en),
      .a(gv2), .b(c8b_ff.item.y2), .p(num2));

   assign c10_in.status = c9b_ff.item.status;
   assign c10_in.t      = c9b_ff.t;
   assign c10_in.fail   = c9b_ff.fail;
   assign c10_in.dsn    = c9b_ff.dsn;

   tpao_div #(.NW(N2W), .DW(SDW), .QW(QE), .CW($bits(c10_type))) u_div_e (
      .clock(clock), .en(en), .n(N2W'(num2) << FRAC_BITS), .d(c9b_ff.den),
      .ctx_in(c10_in), .q(q3), .ovf(ovf3), .ctx_out(c10_out));

   // any ETH out of 2^50 or more saturates the profit either way
   always_comb begin
      emag = ovf3 ? (53'd1 << QE) : 53'(q3);
      e_s  = c10_out.dsn ? -signed'(emag) : signed'(emag);
      t_s  = signed'({{4{c10_out.t[48]}}, c10_out.t});
      p_s  = e_s - t_s;
      if (c10_out.status != ST_OK) begin
         status_in = c10_out.status;
         amount_in = '0;
         profit_in = '0;
      end else if (c10_out.fail) begin
         status_in = ST_DEN;
         amount_in = '0;
         profit_in = '0;
      end else begin
         status_in = ST_OK;
         amount_in = c10_out.t;
         if (p_s > P_MAX) profit_in = MAG_POS;
         else if (p_s < P_MIN) profit_in = MAG_NEG;
         else profit_in = p_s[48:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         it1a_ff   <= in_item;
         it1b_ff   <= it1a_ff;
         c2a_ff    <= c2_in;
         c2b_ff    <= c2a_ff;
         c3a_ff    <= c3_out;
         c3b_ff    <= c3a_ff;
         c5a_ff    <= c5_in;
         c5b_ff    <= c5a_ff;
         c6a_ff    <= c6_in;
         c6b_ff    <= c6a_ff;
         c8a_ff    <= c8_in;
         c8b_ff    <= c8a_ff;
         c9a_ff    <= c9_in;
         c9b_ff    <= c9a_ff;
         amount_ff <= amount_in;
         profit_ff <= profit_in;
         status_ff <= status_in;
      end
   end

   assign out_valid  = vld_ff[LAT-1];
   assign out_amount = amount_ff;
   assign out_profit = profit_ff;
   assign out_status = status_ff;
endmodule
`default_nettype wire

/* rtl/core/two_pool_arbitrage_optimizer.sv */
// Register stages: 233, counting the one loaded at acceptance (2 front, 1 queue, 230 back).
// Throughput: one request per cycle while no response waits on rsp_ready; the bit-per-stage
//   square root and the three bit-per-stage dividers in the back pipeline are fully pipelined.
// Reset: synchronous; clears all valid state and sets the fee register to 197.
`default_nettype none
module two_pool_arbitrage_optimizer #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [31:0]        req_pool_a_eth,
   input  logic [31:0]        req_pool_a_dai,
   input  logic [31:0]        req_pool_b_eth,
   input  logic [31:0]        req_pool_b_dai,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [48:0] rsp_optimal_amount,
   output logic signed [48:0] rsp_profit,
   output logic [1:0]         rsp_status,
   input  logic               csr_we,
   input  logic [15:0]        csr_wdata
);
   import tpao_pkg::*;

   // fee register; gamma = 65536 - fee, never zero
   logic [15:0]   fee_ff;
   logic [16:0]   gamma;

   // front -> queue -> back
   logic          f_valid, f_ready;
   tpao_item_type f_item;
   logic          q_valid, q_ready;
   tpao_item_type q_item;

   always_ff @(posedge clock) begin
      if (reset) fee_ff <= 16'd197;
      else if (csr_we) fee_ff <= csr_wdata;
   end

   assign gamma = 17'h1_0000 - {1'b0, fee_ff};

   // front: take the request, compare prices, pick direction, flag zero reserves
   tpao_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_ready(req_ready),
      .a_eth(req_pool_a_eth), .a_dai(req_pool_a_dai),
      .b_eth(req_pool_b_eth), .b_dai(req_pool_b_dai),
      .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item));

   // two-entry queue decouples the front from back-pipeline stalls
   tpao_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item));

   // back: sqrt, optimal input, two swaps, profit; stalls only on rsp_ready
   tpao_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock(clock), .reset(reset), .gamma(gamma),
      .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
      .out_valid(rsp_valid), .out_ready(rsp_ready),
      .out_amount(rsp_optimal_amount), .out_profit(rsp_profit),
      .out_status(rsp_status));

   // a non-ok status always carries zero amount and profit
   a_zero_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_optimal_amount == '0 && rsp_profit == '0)
      else $error("nonzero fields with error status");

   // a queued request is kept while the back pipeline is stalled
   a_queue_holds: assert property (@(posedge clock) disable iff (reset)
      q_valid && !q_ready |=> q_valid)
      else $error("queued request lost during back stall");

   // pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");
endmodule
`default_nettype wire
